>>> rtl/asp_pkg.sv
// Shared types, widths and helpers for the A* shortest-path core.
// No dependencies; used by the top level by scoped names.
package asp_pkg;

  // Field widths fixed by the interface
  localparam int MODE_W   = 2;
  localparam int NODE_W   = 7;
  localparam int HEUR_W   = 16;
  localparam int WIN_W    = 16;
  localparam int COST_W   = 24;
  localparam int F_W      = 25;

  // Default sizing for the top level parameters
  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_MAX_EDGES   = 256;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

  // Input item modes
  localparam logic [MODE_W-1:0] MODE_EDGE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HEUR   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  // Per-node record: settled mark, predecessor, path cost
  typedef struct packed {
    logic              mark;
    logic [NODE_W-1:0] pred;
    logic [COST_W-1:0] cost;
  } node_ent_t;

  // Open-list entry: f value and node number
  typedef struct packed {
    logic [F_W-1:0]    f;
    logic [NODE_W-1:0] node;
  } heap_ent_t;

  // Heap order: smaller f first, larger node number on a tie
  function automatic logic heap_before(input heap_ent_t x, input heap_ent_t y);
    return (x.f < y.f) || ((x.f == y.f) && (x.node > y.node));
  endfunction

endpackage

>>> rtl/asp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instantiated for every store of the core.
module asp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/astar_shortest_path_core.sv
// A* shortest-path core: edge and heuristic loading, heap-driven search, path output.
// Depends on asp_pkg and asp_ram.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall | mode, edge, heuristic, start/goal fields
//  out_    | output    | out_valid/out_stall | path_node, found, last
//  cfg_    | input     | cfg_valid/cfg_ready | node_count
//
// Edge and heuristic loads are taken in the idle state. A search first clears every
// entry of the node store, then pops the heap, scans every stored edge for each
// settled node and pushes improved neighbours; the single read port of the heap and
// node memories serializes these steps. The path is walked back from the goal into a
// buffer and then sent out from start to goal, one node per transfer.
// Reset is synchronous; edges, heuristic values and node_count return to reset
// values. A stalled result holds until transfer; no new item is taken meanwhile.
module astar_shortest_path_core #(
  parameter int MAX_NODES   = asp_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES   = asp_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = asp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [asp_pkg::MODE_W-1:0] in_mode,
  input  logic [asp_pkg::NODE_W-1:0] in_edge_end_a,
  input  logic [asp_pkg::NODE_W-1:0] in_edge_end_b,
  input  logic [asp_pkg::WIN_W-1:0]  in_edge_weight,
  input  logic [asp_pkg::NODE_W-1:0] in_heur_node,
  input  logic [asp_pkg::HEUR_W-1:0] in_heur_value,
  input  logic [asp_pkg::NODE_W-1:0] in_start_node,
  input  logic [asp_pkg::NODE_W-1:0] in_goal_node,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [asp_pkg::NODE_W-1:0] out_path_node,
  output logic                       out_found,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [asp_pkg::NODE_W-1:0] cfg_node_count
);

  localparam int NODE_W   = asp_pkg::NODE_W;
  localparam int COST_W   = asp_pkg::COST_W;
  localparam int F_W      = asp_pkg::F_W;
  localparam int HEUR_W   = asp_pkg::HEUR_W;
  localparam int NODE_AW  = $clog2(MAX_NODES);
  localparam int LEN_W    = $clog2(MAX_NODES + 1);
  localparam int EA_W     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W     = $clog2(MAX_EDGES + 1);
  localparam int HEAP_CAP = 2 * MAX_EDGES + 1;
  localparam int HA_W     = $clog2(HEAP_CAP);
  localparam int HS_W     = $clog2(HEAP_CAP + 1);
  localparam int ED_W     = 2 * NODE_W + WEIGHT_BITS;
  localparam int WX_W     = (WEIGHT_BITS > asp_pkg::WIN_W) ? WEIGHT_BITS : asp_pkg::WIN_W;
  localparam int SUM_W    = ((WEIGHT_BITS > COST_W) ? WEIGHT_BITS : COST_W) + 1;

  // Sequencer states
  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] S_CLR      = 5'd1;
  localparam logic [ST_W-1:0] S_PUSH_RD  = 5'd2;
  localparam logic [ST_W-1:0] S_PUSH_CMP = 5'd3;
  localparam logic [ST_W-1:0] S_POP0     = 5'd4;
  localparam logic [ST_W-1:0] S_POP1     = 5'd5;
  localparam logic [ST_W-1:0] S_POP2     = 5'd6;
  localparam logic [ST_W-1:0] S_SD_L     = 5'd7;
  localparam logic [ST_W-1:0] S_SD_R     = 5'd8;
  localparam logic [ST_W-1:0] S_SD_CMP   = 5'd9;
  localparam logic [ST_W-1:0] S_POPPED   = 5'd10;
  localparam logic [ST_W-1:0] S_MARK_CHK = 5'd11;
  localparam logic [ST_W-1:0] S_EDGE_RD  = 5'd12;
  localparam logic [ST_W-1:0] S_EDGE_LD  = 5'd13;
  localparam logic [ST_W-1:0] S_SIDE     = 5'd14;
  localparam logic [ST_W-1:0] S_RLX_CHK  = 5'd15;
  localparam logic [ST_W-1:0] S_ADV      = 5'd16;
  localparam logic [ST_W-1:0] S_GOAL_RD  = 5'd17;
  localparam logic [ST_W-1:0] S_GOAL_CHK = 5'd18;
  localparam logic [ST_W-1:0] S_WALK     = 5'd19;
  localparam logic [ST_W-1:0] S_WALK_LD  = 5'd20;
  localparam logic [ST_W-1:0] S_OUT_RD   = 5'd21;
  localparam logic [ST_W-1:0] S_OUT_LD   = 5'd22;
  localparam logic [ST_W-1:0] S_OUT      = 5'd23;

  // Node number 1..MAX_NODES to store address
  function automatic logic [NODE_AW-1:0] naddr(input logic [NODE_W-1:0] x);
    logic [NODE_W-1:0] xm;
    xm = x - NODE_W'(1);
    return xm[NODE_AW-1:0];
  endfunction

  // Heap size to heap address
  function automatic logic [HA_W-1:0] hi_w(input logic [HS_W-1:0] x);
    return x[HA_W-1:0];
  endfunction

  // Registers
  logic [ST_W-1:0]          state_r, state_nxt;
  logic [NODE_W-1:0]        node_count_r, node_count_nxt;
  logic [EC_W-1:0]          edge_count_r, edge_count_nxt;
  logic [MAX_NODES-1:0]     hvalid_r, hvalid_nxt;
  logic [HS_W-1:0]          heap_size_r, heap_size_nxt;
  logic [NODE_AW-1:0]       clr_idx_r, clr_idx_nxt;
  logic [NODE_W-1:0]        start_r, start_nxt;
  logic [NODE_W-1:0]        goal_r, goal_nxt;
  asp_pkg::heap_ent_t       top_r, top_nxt;
  asp_pkg::heap_ent_t       item_r, item_nxt;
  asp_pkg::heap_ent_t       best_r, best_nxt;
  logic [HS_W-1:0]          hi_r, hi_nxt;
  logic [HS_W-1:0]          bidx_r, bidx_nxt;
  logic                     rvalid_r, rvalid_nxt;
  logic                     push_ret_r, push_ret_nxt;
  logic [COST_W-1:0]        cost_u_r, cost_u_nxt;
  logic [EC_W-1:0]          edge_idx_r, edge_idx_nxt;
  logic [ED_W-1:0]          ed_r, ed_nxt;
  logic                     side_r, side_nxt;
  logic [NODE_W-1:0]        v_r, v_nxt;
  logic [COST_W-1:0]        c_r, c_nxt;
  logic [NODE_W-1:0]        cur_r, cur_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [LEN_W-1:0]         oidx_r, oidx_nxt;
  logic [NODE_W-1:0]        out_node_r, out_node_nxt;
  logic                     out_found_r, out_found_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     hv_r;

  // Memory ports
  logic                     node_we;
  logic [NODE_AW-1:0]       node_waddr, node_raddr;
  asp_pkg::node_ent_t       node_wdata, node_rd;
  logic                     heap_we;
  logic [HA_W-1:0]          heap_waddr, heap_raddr;
  asp_pkg::heap_ent_t       heap_wdata, heap_rd;
  logic                     edge_we;
  logic [EA_W-1:0]          edge_waddr, edge_raddr;
  logic [ED_W-1:0]          edge_wdata, edge_rd;
  logic                     heur_we;
  logic [NODE_AW-1:0]       heur_waddr, heur_raddr;
  logic [HEUR_W-1:0]        heur_wdata, heur_rd;
  logic                     path_we;
  logic [NODE_AW-1:0]       path_waddr, path_raddr;
  logic [NODE_W-1:0]        path_wdata, path_rd;

  asp_ram #(.WIDTH($bits(asp_pkg::node_ent_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rd)
  );
  asp_ram #(.WIDTH($bits(asp_pkg::heap_ent_t)), .DEPTH(HEAP_CAP)) u_heap_ram (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rd)
  );
  asp_ram #(.WIDTH(ED_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rd)
  );
  asp_ram #(.WIDTH(HEUR_W), .DEPTH(MAX_NODES)) u_heur_ram (
    .clk(clk), .we(heur_we), .waddr(heur_waddr), .wdata(heur_wdata),
    .raddr(heur_raddr), .rdata(heur_rd)
  );
  asp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_path_ram (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
    .raddr(path_raddr), .rdata(path_rd)
  );

  // Effective node count, clamped to 1..MAX_NODES
  logic [NODE_W-1:0] n_eff;
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NODE_W'(1);
    end else if (node_count_r > NODE_W'(MAX_NODES)) begin
      n_eff = NODE_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  // Edge fields and weight as stored
  logic [NODE_W-1:0]      ed_a, ed_b;
  logic [WEIGHT_BITS-1:0] ed_w;
  logic [WX_W-1:0]        w_ext;
  assign ed_a  = ed_r[ED_W-1 -: NODE_W];
  assign ed_b  = ed_r[WEIGHT_BITS+NODE_W-1 -: NODE_W];
  assign ed_w  = ed_r[WEIGHT_BITS-1:0];
  assign w_ext = WX_W'(in_edge_weight);

  // Neighbour selection for the current side of the edge
  logic              side_match;
  logic [NODE_W-1:0] v_sel;
  assign side_match = side_r ? (ed_b == top_r.node) : (ed_a == top_r.node);
  assign v_sel      = side_r ? ed_a : ed_b;

  // Saturating candidate cost
  logic [SUM_W-1:0]  c_sum;
  logic [COST_W-1:0] c_sat;
  assign c_sum = SUM_W'(cost_u_r) + SUM_W'(ed_w);
  assign c_sat = (c_sum >= SUM_W'(asp_pkg::COST_INF)) ? (asp_pkg::COST_INF - COST_W'(1))
                                                      : c_sum[COST_W-1:0];

  // Heuristic value, zero for nodes never loaded
  logic [HEUR_W-1:0] h_eff;
  assign h_eff = hv_r ? heur_rd : '0;

  // Heap child and parent indices
  logic [HS_W:0] l_idx, r_idx;
  logic [HS_W-1:0] p_idx;
  assign l_idx = {hi_r, 1'b1};
  assign r_idx = l_idx + (HS_W+1)'(1);
  assign p_idx = (hi_r - HS_W'(1)) >> 1;

  logic              sd_l_before;
  logic              sd_r_before;
  logic [LEN_W-1:0]  out_pos;
  assign sd_l_before = asp_pkg::heap_before(heap_rd, item_r);
  assign sd_r_before = rvalid_r && asp_pkg::heap_before(heap_rd, best_r);
  assign out_pos     = len_r - LEN_W'(1) - oidx_r;

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    edge_count_nxt = edge_count_r;
    hvalid_nxt     = hvalid_r;
    heap_size_nxt  = heap_size_r;
    clr_idx_nxt    = clr_idx_r;
    start_nxt      = start_r;
    goal_nxt       = goal_r;
    top_nxt        = top_r;
    item_nxt       = item_r;
    best_nxt       = best_r;
    hi_nxt         = hi_r;
    bidx_nxt       = bidx_r;
    rvalid_nxt     = rvalid_r;
    push_ret_nxt   = push_ret_r;
    cost_u_nxt     = cost_u_r;
    edge_idx_nxt   = edge_idx_r;
    ed_nxt         = ed_r;
    side_nxt       = side_r;
    v_nxt          = v_r;
    c_nxt          = c_r;
    cur_nxt        = cur_r;
    len_nxt        = len_r;
    oidx_nxt       = oidx_r;
    out_node_nxt   = out_node_r;
    out_found_nxt  = out_found_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r;

    node_we    = 1'b0;
    node_waddr = clr_idx_r;
    node_wdata = '{mark: 1'b0, pred: '0, cost: asp_pkg::COST_INF};
    node_raddr = naddr(top_r.node);
    heap_we    = 1'b0;
    heap_waddr = hi_r[HA_W-1:0];
    heap_wdata = item_r;
    heap_raddr = '0;
    edge_we    = 1'b0;
    edge_waddr = edge_count_r[EA_W-1:0];
    edge_wdata = {in_edge_end_a, in_edge_end_b, w_ext[WEIGHT_BITS-1:0]};
    edge_raddr = edge_idx_r[EA_W-1:0];
    heur_we    = 1'b0;
    heur_waddr = naddr(in_heur_node);
    heur_wdata = in_heur_value;
    heur_raddr = (state_r == S_SIDE) ? naddr(v_sel) : naddr(start_r);
    path_we    = 1'b0;
    path_waddr = len_r[NODE_AW-1:0];
    path_wdata = cur_r;
    path_raddr = out_pos[NODE_AW-1:0];

    // Take a configuration write
    if (cfg_valid && cfg_ready) begin
      node_count_nxt = cfg_node_count;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_mode)
            asp_pkg::MODE_EDGE: begin
              if (edge_count_r < EC_W'(MAX_EDGES)) begin
                edge_we        = 1'b1;
                edge_count_nxt = edge_count_r + EC_W'(1);
              end
            end
            asp_pkg::MODE_HEUR: begin
              if (in_heur_node != '0 && in_heur_node <= NODE_W'(MAX_NODES)) begin
                heur_we                        = 1'b1;
                hvalid_nxt[naddr(in_heur_node)] = 1'b1;
              end
            end
            asp_pkg::MODE_SEARCH: begin
              start_nxt = in_start_node;
              goal_nxt  = in_goal_node;
              if (in_start_node == '0 || in_start_node > n_eff ||
                  in_goal_node == '0 || in_goal_node > n_eff) begin
                out_node_nxt  = '0;
                out_found_nxt = 1'b0;
                out_last_nxt  = 1'b1;
                out_valid_nxt = 1'b1;
                state_nxt     = S_OUT;
              end else begin
                clr_idx_nxt = '0;
                state_nxt   = S_CLR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Clear the node store, seed the start, then push it
      S_CLR: begin
        node_we    = 1'b1;
        node_waddr = clr_idx_r;
        if (clr_idx_r == naddr(start_r)) begin
          node_wdata = '{mark: 1'b0, pred: '0, cost: '0};
        end
        clr_idx_nxt = clr_idx_r + NODE_AW'(1);
        if (clr_idx_r == NODE_AW'(MAX_NODES - 1)) begin
          item_nxt      = '{f: F_W'(h_eff), node: start_r};
          hi_nxt        = '0;
          heap_size_nxt = HS_W'(1);
          push_ret_nxt  = 1'b0;
          state_nxt     = S_PUSH_RD;
        end
      end

      // Sift up: read parent or settle at the root
      S_PUSH_RD: begin
        if (hi_r == '0) begin
          heap_we    = 1'b1;
          heap_waddr = '0;
          heap_wdata = item_r;
          state_nxt  = push_ret_r ? S_ADV : S_POP0;
        end else begin
          heap_raddr = p_idx[HA_W-1:0];
          state_nxt  = S_PUSH_CMP;
        end
      end

      S_PUSH_CMP: begin
        heap_we    = 1'b1;
        heap_waddr = hi_r[HA_W-1:0];
        if (asp_pkg::heap_before(item_r, heap_rd)) begin
          heap_wdata = heap_rd;
          hi_nxt     = p_idx;
          state_nxt  = S_PUSH_RD;
        end else begin
          heap_wdata = item_r;
          state_nxt  = push_ret_r ? S_ADV : S_POP0;
        end
      end

      // Pop: read the top, then the last entry
      S_POP0: begin
        heap_raddr = '0;
        state_nxt  = (heap_size_r == '0) ? S_GOAL_RD : S_POP1;
      end

      S_POP1: begin
        top_nxt       = heap_rd;
        heap_raddr    = hi_w(heap_size_r - HS_W'(1));
        heap_size_nxt = heap_size_r - HS_W'(1);
        state_nxt     = S_POP2;
      end

      S_POP2: begin
        item_nxt  = heap_rd;
        hi_nxt    = '0;
        state_nxt = (heap_size_r == '0) ? S_POPPED : S_SD_L;
      end

      // Sift down with the last entry held as the hole item
      S_SD_L: begin
        if (l_idx >= (HS_W+1)'(heap_size_r)) begin
          heap_we    = 1'b1;
          heap_wdata = item_r;
          state_nxt  = S_POPPED;
        end else begin
          heap_raddr = l_idx[HA_W-1:0];
          state_nxt  = S_SD_R;
        end
      end

      S_SD_R: begin
        if (sd_l_before) begin
          best_nxt = heap_rd;
          bidx_nxt = l_idx[HS_W-1:0];
        end else begin
          best_nxt = item_r;
          bidx_nxt = hi_r;
        end
        rvalid_nxt = r_idx < (HS_W+1)'(heap_size_r);
        heap_raddr = r_idx[HA_W-1:0];
        state_nxt  = S_SD_CMP;
      end

      S_SD_CMP: begin
        heap_we = 1'b1;
        if (sd_r_before) begin
          heap_wdata = heap_rd;
          hi_nxt     = r_idx[HS_W-1:0];
          state_nxt  = S_SD_L;
        end else if (bidx_r != hi_r) begin
          heap_wdata = best_r;
          hi_nxt     = bidx_r;
          state_nxt  = S_SD_L;
        end else begin
          heap_wdata = item_r;
          state_nxt  = S_POPPED;
        end
      end

      // Stop at the goal, else fetch the popped node's record
      S_POPPED: begin
        node_raddr = naddr(top_r.node);
        state_nxt  = (top_r.node == goal_r) ? S_GOAL_RD : S_MARK_CHK;
      end

      S_MARK_CHK: begin
        if (node_rd.mark) begin
          state_nxt = S_POP0;
        end else begin
          node_we      = 1'b1;
          node_waddr   = naddr(top_r.node);
          node_wdata   = '{mark: 1'b1, pred: node_rd.pred, cost: node_rd.cost};
          cost_u_nxt   = node_rd.cost;
          edge_idx_nxt = '0;
          state_nxt    = S_EDGE_RD;
        end
      end

      // Scan edges in load order
      S_EDGE_RD: begin
        edge_raddr = edge_idx_r[EA_W-1:0];
        state_nxt  = (edge_idx_r >= edge_count_r) ? S_POP0 : S_EDGE_LD;
      end

      S_EDGE_LD: begin
        ed_nxt    = edge_rd;
        side_nxt  = 1'b0;
        state_nxt = S_SIDE;
      end

      S_SIDE: begin
        v_nxt      = v_sel;
        c_nxt      = c_sat;
        node_raddr = naddr(v_sel);
        if (side_match && v_sel != '0 && v_sel <= n_eff) begin
          state_nxt = S_RLX_CHK;
        end else begin
          state_nxt = S_ADV;
        end
      end

      // Relax an unmarked neighbour on strict improvement
      S_RLX_CHK: begin
        if (!node_rd.mark && node_rd.cost > c_r) begin
          node_we    = 1'b1;
          node_waddr = naddr(v_r);
          node_wdata = '{mark: 1'b0, pred: top_r.node, cost: c_r};
          if (heap_size_r >= HS_W'(HEAP_CAP)) begin
            state_nxt = S_ADV;
          end else begin
            item_nxt      = '{f: F_W'(c_r) + F_W'(h_eff), node: v_r};
            hi_nxt        = heap_size_r;
            heap_size_nxt = heap_size_r + HS_W'(1);
            push_ret_nxt  = 1'b1;
            state_nxt     = S_PUSH_RD;
          end
        end else begin
          state_nxt = S_ADV;
        end
      end

      // Advance to the other endpoint or the next edge
      S_ADV: begin
        if (!side_r) begin
          side_nxt  = 1'b1;
          state_nxt = S_SIDE;
        end else begin
          edge_idx_nxt = edge_idx_r + EC_W'(1);
          state_nxt    = S_EDGE_RD;
        end
      end

      S_GOAL_RD: begin
        node_raddr = naddr(goal_r);
        state_nxt  = S_GOAL_CHK;
      end

      S_GOAL_CHK: begin
        if (node_rd.cost == asp_pkg::COST_INF) begin
          out_node_nxt  = '0;
          out_found_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cur_nxt   = goal_r;
          len_nxt   = '0;
          state_nxt = S_WALK;
        end
      end

      // Walk predecessors back from the goal into the path buffer
      S_WALK: begin
        if (cur_r == '0 || len_r == LEN_W'(MAX_NODES)) begin
          oidx_nxt  = '0;
          state_nxt = S_OUT_RD;
        end else begin
          path_we    = 1'b1;
          path_waddr = len_r[NODE_AW-1:0];
          path_wdata = cur_r;
          len_nxt    = len_r + LEN_W'(1);
          node_raddr = naddr(cur_r);
          state_nxt  = S_WALK_LD;
        end
      end

      S_WALK_LD: begin
        cur_nxt   = node_rd.pred;
        state_nxt = S_WALK;
      end

      // Send the path from start to goal
      S_OUT_RD: begin
        path_raddr = out_pos[NODE_AW-1:0];
        state_nxt  = S_OUT_LD;
      end

      S_OUT_LD: begin
        out_node_nxt  = path_rd;
        out_found_nxt = 1'b1;
        out_last_nxt  = (oidx_r + LEN_W'(1)) == len_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end

      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            oidx_nxt  = oidx_r + LEN_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_W'(MAX_NODES);
      edge_count_r <= '0;
      hvalid_r     <= '0;
      heap_size_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      edge_count_r <= edge_count_nxt;
      hvalid_r     <= hvalid_nxt;
      heap_size_r  <= heap_size_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    clr_idx_r   <= clr_idx_nxt;
    start_r     <= start_nxt;
    goal_r      <= goal_nxt;
    top_r       <= top_nxt;
    item_r      <= item_nxt;
    best_r      <= best_nxt;
    hi_r        <= hi_nxt;
    bidx_r      <= bidx_nxt;
    rvalid_r    <= rvalid_nxt;
    push_ret_r  <= push_ret_nxt;
    cost_u_r    <= cost_u_nxt;
    edge_idx_r  <= edge_idx_nxt;
    ed_r        <= ed_nxt;
    side_r      <= side_nxt;
    v_r         <= v_nxt;
    c_r         <= c_nxt;
    cur_r       <= cur_nxt;
    len_r       <= len_nxt;
    oidx_r      <= oidx_nxt;
    out_node_r  <= out_node_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
    hv_r        <= hvalid_r[heur_raddr];
  end

  assign in_stall      = (state_r != S_IDLE);
  assign cfg_ready     = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_path_node = out_node_r;
  assign out_found     = out_found_r;
  assign out_last      = out_last_r;

  // Checks
  a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    heap_size_r <= HS_W'(HEAP_CAP))
    else $error("heap size beyond capacity");

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_count_r <= EC_W'(MAX_EDGES))
    else $error("edge count beyond capacity");

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result shown outside output state");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && out_last_r) |=> (state_r == S_IDLE))
    else $error("search did not end after last transfer");

  a_path_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_LD) |-> (len_r != '0 && oidx_r < len_r))
    else $error("path read outside buffered length");

endmodule
